// File: hw/rtl/cifs_pkg.sv
// Shared types and constants for the connection-ID flow steering block.
// No dependencies; every other file in hw/rtl except cifs_ram imports this package.
package cifs_pkg;

    // Fixed field widths of the request and result ports
    localparam int ACTION_W = 3;
    localparam int KEY_W    = 64;
    localparam int WORKER_W = 8;
    localparam int STATUS_W = 2;
    localparam int TOTAL_W  = 5;

    // Defaults for the top-level parameters
    localparam int FLOW_ENTRIES_DEF   = 64;
    localparam int MAX_WORKERS_DEF    = 16;
    localparam int WORKER_ID_BITS_DEF = 8;

    // Request action codes
    localparam logic [ACTION_W-1:0] ACT_ADD    = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_REMOVE = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_REG    = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_UNREG  = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_LOOKUP = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_ALLOC  = 3'd5;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NOWORK   = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd3;

    // Sequencer states of the top level
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_FLOW_FIN,
        S_UNREG,
        S_DIV,
        S_ALLOC_OUT
    } t_state;

endpackage

// File: hw/rtl/cifs_ram.sv
// Simple dual-port synchronous RAM: one write port, one read port,
// registered read data. No dependencies.
module cifs_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule

// File: hw/rtl/cifs_mod_unit.sv
// Bit-serial remainder unit: 64-bit dividend modulo a small divisor,
// one quotient bit a cycle. Depends on cifs_pkg.
module cifs_mod_unit #(
    parameter int CNT_W = 5
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [cifs_pkg::KEY_W-1:0] i_dividend,
    input  logic [CNT_W-1:0]          i_divisor,
    output logic                      o_done,
    output logic [CNT_W-1:0]          o_rem
);
    import cifs_pkg::*;

    localparam int STEP_W = $clog2(KEY_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(KEY_W - 1);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [STEP_W-1:0] r_step, n_step;
    logic [KEY_W-1:0]  r_dvd,  n_dvd;
    logic [CNT_W-1:0]  r_div,  n_div;
    logic [CNT_W-1:0]  r_rem,  n_rem;
    logic [CNT_W:0]    trial;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_step = r_step;
        n_dvd  = r_dvd;
        n_div  = r_div;
        n_rem  = r_rem;
        trial  = {r_rem, r_dvd[KEY_W-1]};
        if (i_start) begin
            n_busy = 1'b1;
            n_step = '0;
            n_dvd  = i_dividend;
            n_div  = i_divisor;
            n_rem  = '0;
        end else if (r_busy) begin
            if (trial >= {1'b0, r_div}) begin
                n_rem = CNT_W'(trial - {1'b0, r_div});
            end else begin
                n_rem = trial[CNT_W-1:0];
            end
            n_dvd  = {r_dvd[KEY_W-2:0], 1'b0};
            n_step = r_step + 1'b1;
            if (r_step == LAST_STEP) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_step <= n_step;
        r_dvd  <= n_dvd;
        r_div  <= n_div;
        r_rem  <= n_rem;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// File: hw/rtl/connection_id_flow_steering.sv
// Register, undefined actions and empty-list cases answer in the cycle after the request;
// add/remove/lookup scan the flow RAM one entry a cycle; unregister walks the worker list;
// allocate waits on the 64-step remainder unit. Throughput: one request at a time; busy is
// high from acceptance until the result strobe, except for requests answered at once.
// Reset (synchronous, active low) starts a pass clearing the flow RAM's valid bits with
// busy high; the result receiver cannot stall. Depends on cifs_pkg and submodules.
module connection_id_flow_steering #(
    parameter int FLOW_ENTRIES   = cifs_pkg::FLOW_ENTRIES_DEF,
    parameter int MAX_WORKERS    = cifs_pkg::MAX_WORKERS_DEF,
    parameter int WORKER_ID_BITS = cifs_pkg::WORKER_ID_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [cifs_pkg::ACTION_W-1:0] i_action,
    input  logic [cifs_pkg::KEY_W-1:0]    i_cid_key,
    input  logic [cifs_pkg::WORKER_W-1:0] i_worker,
    output logic                          o_valid,
    output logic [cifs_pkg::WORKER_W-1:0] o_worker_out,
    output logic                          o_hit,
    output logic [cifs_pkg::STATUS_W-1:0] o_status,
    output logic [cifs_pkg::TOTAL_W-1:0]  o_worker_total
);
    import cifs_pkg::*;

    // Stored worker id width: the id field cut to WORKER_ID_BITS
    localparam int WW  = (WORKER_ID_BITS < WORKER_W) ? WORKER_ID_BITS : WORKER_W;
    localparam int AW  = $clog2(FLOW_ENTRIES);
    localparam int FW  = 1 + WW + KEY_W;
    localparam int LAW = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
    localparam int CW  = $clog2(MAX_WORKERS + 1);
    localparam logic [AW:0]   FE_END    = (AW+1)'(FLOW_ENTRIES);
    localparam logic [AW-1:0] FE_LAST   = AW'(FLOW_ENTRIES - 1);
    localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_WORKERS);

    t_state r_state, n_state;

    logic [ACTION_W-1:0] r_action, n_action;
    logic [KEY_W-1:0]    r_key,    n_key;
    logic [WW-1:0]       r_wid,    n_wid;
    logic [AW:0]         r_ptr,    n_ptr;
    logic                r_chk,    n_chk;
    logic [AW-1:0]       r_chk_idx, n_chk_idx;
    logic                r_found,  n_found;
    logic [AW-1:0]       r_slot,   n_slot;
    logic                r_free_ok, n_free_ok;
    logic [AW-1:0]       r_free,   n_free;
    logic [WW-1:0]       r_fworker, n_fworker;
    logic [CW-1:0]       r_count,  n_count;
    logic [CW-1:0]       r_keep,   n_keep;
    logic [CW-1:0]       r_lptr,   n_lptr;
    logic                r_lchk,   n_lchk;
    logic [CW-1:0]       r_lchk_idx, n_lchk_idx;
    logic [KEY_W-1:0]    r_rot,    n_rot;
    logic                r_valid,  n_valid;
    logic [WORKER_W-1:0] r_wout,   n_wout;
    logic                r_hit,    n_hit;
    logic [STATUS_W-1:0] r_status, n_status;

    // Flow RAM ports
    logic          fl_we, fl_re;
    logic [AW-1:0] fl_waddr, fl_raddr;
    logic [FW-1:0] fl_wdata, fl_rdata;
    logic          fl_ev;
    logic [KEY_W-1:0] fl_ek;
    logic [WW-1:0] fl_ew;

    // Worker list RAM ports
    logic           wl_we, wl_re;
    logic [LAW-1:0] wl_waddr, wl_raddr;
    logic [WW-1:0]  wl_wdata, wl_rdata;

    // Remainder unit
    logic          mod_start, mod_done;
    logic [CW-1:0] mod_rem;

    logic [31:0]   count_ext;

    cifs_ram #(.DATA_W(FW), .DEPTH(FLOW_ENTRIES)) u_flow_ram (
        .i_clk   (i_clk),
        .i_we    (fl_we),
        .i_waddr (fl_waddr),
        .i_wdata (fl_wdata),
        .i_re    (fl_re),
        .i_raddr (fl_raddr),
        .o_rdata (fl_rdata)
    );

    cifs_ram #(.DATA_W(WW), .DEPTH(MAX_WORKERS)) u_list_ram (
        .i_clk   (i_clk),
        .i_we    (wl_we),
        .i_waddr (wl_waddr),
        .i_wdata (wl_wdata),
        .i_re    (wl_re),
        .i_raddr (wl_raddr),
        .o_rdata (wl_rdata)
    );

    cifs_mod_unit #(.CNT_W(CW)) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (r_rot),
        .i_divisor  (r_count),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    // Split a flow entry into valid, worker and key
    assign fl_ev = fl_rdata[FW-1];
    assign fl_ew = fl_rdata[KEY_W +: WW];
    assign fl_ek = fl_rdata[KEY_W-1:0];

    // Next state, memory controls and result
    always_comb begin
        n_state    = r_state;
        n_action   = r_action;
        n_key      = r_key;
        n_wid      = r_wid;
        n_ptr      = r_ptr;
        n_chk      = 1'b0;
        n_chk_idx  = r_ptr[AW-1:0];
        n_found    = r_found;
        n_slot     = r_slot;
        n_free_ok  = r_free_ok;
        n_free     = r_free;
        n_fworker  = r_fworker;
        n_count    = r_count;
        n_keep     = r_keep;
        n_lptr     = r_lptr;
        n_lchk     = 1'b0;
        n_lchk_idx = r_lptr;
        n_rot      = r_rot;
        n_valid    = 1'b0;
        n_wout     = r_wout;
        n_hit      = r_hit;
        n_status   = r_status;

        fl_we    = 1'b0;
        fl_waddr = r_ptr[AW-1:0];
        fl_wdata = '0;
        fl_re    = 1'b0;
        fl_raddr = r_ptr[AW-1:0];
        wl_we    = 1'b0;
        wl_waddr = r_count[LAW-1:0];
        wl_wdata = r_wid;
        wl_re    = 1'b0;
        wl_raddr = r_lptr[LAW-1:0];
        mod_start = 1'b0;

        case (r_state)
            // Clear every valid bit after reset
            S_CLEAR: begin
                fl_we = 1'b1;
                n_ptr = r_ptr + 1'b1;
                if (r_ptr[AW-1:0] == FE_LAST) begin
                    n_state = S_IDLE;
                end
            end

            // Take a request; answer the short actions at once
            S_IDLE: begin
                if (start) begin
                    n_action  = i_action;
                    n_key     = i_cid_key;
                    n_wid     = i_worker[WW-1:0];
                    n_ptr     = '0;
                    n_found   = 1'b0;
                    n_free_ok = 1'b0;
                    n_lptr    = '0;
                    n_keep    = '0;
                    n_wout    = '0;
                    n_hit     = 1'b0;
                    n_status  = STAT_OK;
                    case (i_action)
                        ACT_ADD, ACT_REMOVE, ACT_LOOKUP: begin
                            n_state = S_SCAN;
                        end
                        ACT_REG: begin
                            n_valid = 1'b1;
                            if (r_count >= MAX_COUNT) begin
                                n_status = STAT_FULL;
                            end else begin
                                wl_we    = 1'b1;
                                wl_wdata = i_worker[WW-1:0];
                                n_count  = r_count + 1'b1;
                            end
                        end
                        ACT_UNREG: begin
                            if (r_count == '0) begin
                                n_valid = 1'b1;
                            end else begin
                                n_state = S_UNREG;
                            end
                        end
                        ACT_ALLOC: begin
                            if (r_count == '0) begin
                                n_valid  = 1'b1;
                                n_status = STAT_NOWORK;
                            end else begin
                                mod_start = 1'b1;
                                n_state   = S_DIV;
                            end
                        end
                        default: begin
                            n_valid = 1'b1;
                        end
                    endcase
                end
            end

            // Read one entry a cycle, check the entry read the cycle before
            S_SCAN: begin
                if (r_ptr < FE_END) begin
                    fl_re     = 1'b1;
                    n_ptr     = r_ptr + 1'b1;
                    n_chk     = 1'b1;
                end
                if (r_chk) begin
                    if (fl_ev && (fl_ek == r_key)) begin
                        n_found   = 1'b1;
                        n_slot    = r_chk_idx;
                        n_fworker = fl_ew;
                        n_state   = S_FLOW_FIN;
                    end else begin
                        if (!fl_ev && !r_free_ok) begin
                            n_free_ok = 1'b1;
                            n_free    = r_chk_idx;
                        end
                        if (r_chk_idx == FE_LAST) begin
                            n_state = S_FLOW_FIN;
                        end
                    end
                end
            end

            // Write back the entry for add or remove, and report
            S_FLOW_FIN: begin
                n_valid = 1'b1;
                n_state = S_IDLE;
                case (r_action)
                    ACT_ADD: begin
                        fl_wdata = {1'b1, r_wid, r_key};
                        if (r_found) begin
                            fl_we    = 1'b1;
                            fl_waddr = r_slot;
                        end else if (r_free_ok) begin
                            fl_we    = 1'b1;
                            fl_waddr = r_free;
                        end else begin
                            n_status = STAT_FULL;
                        end
                    end
                    ACT_REMOVE: begin
                        fl_waddr = r_slot;
                        if (r_found) begin
                            fl_we = 1'b1;
                        end else begin
                            n_status = STAT_NOTFOUND;
                        end
                    end
                    default: begin
                        if (r_found) begin
                            n_hit  = 1'b1;
                            n_wout = WORKER_W'(r_fworker);
                        end else begin
                            n_status = STAT_NOTFOUND;
                        end
                    end
                endcase
            end

            // Compact the list: copy every worker other than the one removed down to the keep index
            S_UNREG: begin
                if (r_lptr < r_count) begin
                    wl_re  = 1'b1;
                    n_lptr = r_lptr + 1'b1;
                    n_lchk = 1'b1;
                end
                if (r_lchk) begin
                    if (wl_rdata != r_wid) begin
                        wl_we    = 1'b1;
                        wl_waddr = r_keep[LAW-1:0];
                        wl_wdata = wl_rdata;
                        n_keep   = r_keep + 1'b1;
                    end
                    if (r_lchk_idx == r_count - 1'b1) begin
                        n_count = n_keep;
                        n_valid = 1'b1;
                        n_state = S_IDLE;
                    end
                end
            end

            // Wait for the remainder, then read the chosen worker
            S_DIV: begin
                if (mod_done) begin
                    wl_re    = 1'b1;
                    wl_raddr = mod_rem[LAW-1:0];
                    n_state  = S_ALLOC_OUT;
                end
            end

            // Report the chosen worker and advance the rotation counter
            S_ALLOC_OUT: begin
                n_valid = 1'b1;
                n_hit   = 1'b1;
                n_wout  = WORKER_W'(wl_rdata);
                n_rot   = r_rot + 1'b1;
                n_state = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and payload registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_ptr   <= '0;
            r_chk   <= 1'b0;
            r_lchk  <= 1'b0;
            r_count <= '0;
            r_rot   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ptr   <= n_ptr;
            r_chk   <= n_chk;
            r_lchk  <= n_lchk;
            r_count <= n_count;
            r_rot   <= n_rot;
            r_valid <= n_valid;
        end
        r_action   <= n_action;
        r_key      <= n_key;
        r_wid      <= n_wid;
        r_chk_idx  <= n_chk_idx;
        r_found    <= n_found;
        r_slot     <= n_slot;
        r_free_ok  <= n_free_ok;
        r_free     <= n_free;
        r_fworker  <= n_fworker;
        r_keep     <= n_keep;
        r_lptr     <= n_lptr;
        r_lchk_idx <= n_lchk_idx;
        r_wout     <= n_wout;
        r_hit      <= n_hit;
        r_status   <= n_status;
    end

    // Drive the result ports
    assign count_ext      = 32'(r_count);
    assign busy           = (r_state != S_IDLE);
    assign o_valid        = r_valid;
    assign o_worker_out   = r_wout;
    assign o_hit          = r_hit;
    assign o_status       = r_status;
    assign o_worker_total = count_ext[TOTAL_W-1:0];

endmodule

// File: hw/rtl/cifs_checker.sv
// Port-level checks for connection_id_flow_steering, attached by bind.
// Depends on cifs_pkg and the top level's port list.
module cifs_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          o_valid,
    input logic [cifs_pkg::WORKER_W-1:0] o_worker_out,
    input logic                          o_hit,
    input logic [cifs_pkg::STATUS_W-1:0] o_status,
    input logic [cifs_pkg::TOTAL_W-1:0]  o_worker_total
);
    import cifs_pkg::*;

    // An accepted request either answers at once or holds busy
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_valid))
        else $error("request accepted but neither busy nor answered");

    // A result only appears once the block has gone idle
    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    // A hit always carries ok status
    a_hit_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_hit) |-> (o_status == STAT_OK))
        else $error("hit with non-ok status");

    // A miss reports worker zero
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_hit) |-> (o_worker_out == '0))
        else $error("miss with non-zero worker");

    // No-worker status only with an empty list
    a_nowork_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == STAT_NOWORK)) |-> (o_worker_total == '0))
        else $error("no-worker status with a non-empty list");

endmodule

bind connection_id_flow_steering cifs_checker u_cifs_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_valid        (o_valid),
    .o_worker_out   (o_worker_out),
    .o_hit          (o_hit),
    .o_status       (o_status),
    .o_worker_total (o_worker_total)
);

// File: test/tb.sv
// Self-checking testbench for connection_id_flow_steering: a directed opening, then random requests.
// Results are checked in order against a scoreboard that predicts the flow table and worker list.
// Depends on cifs_pkg and the connection_id_flow_steering RTL.
`timescale 1ns / 100ps

module tb;
    import cifs_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 9;
    localparam int FLOW_SLOTS    = FLOW_ENTRIES_DEF;
    localparam int LIST_SLOTS    = MAX_WORKERS_DEF;
    localparam logic [WORKER_W-1:0] ID_MASK = WORKER_W'((1 << WORKER_ID_BITS_DEF) - 1);
    localparam logic [ACTION_W-1:0] ACT_SPARE_LO = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_SPARE_HI = 3'd7;
    localparam int KEY_POOL_SIZE    = 80;
    localparam int WORKER_POOL_SIZE = 8;
    localparam int PHASES           = 4;
    localparam int REQS_PER_PHASE   = 470;
    localparam int SETTLE_LIMIT     = 200;
    localparam int DRAIN_CYCLES     = 80;
    localparam int MAX_PRINTED      = 40;
    localparam int TIMEOUT_NS       = 12_000_000;

    // Action mix per phase, in percent: add, remove, register, unregister, lookup,
    // allocate, spare codes
    localparam int MIX [PHASES][7] = '{
        '{30, 12, 12,  6, 20, 17, 3},
        '{45,  8, 18,  4, 12, 11, 2},
        '{20, 30,  8, 12, 15, 13, 2},
        '{30, 12, 12,  6, 20, 17, 3}
    };
    // Chance that the sender idles after a request, per phase
    localparam int IDLE_PCT [PHASES] = '{0, 46, 0, 26};

    typedef struct packed {
        logic [WORKER_W-1:0] worker_out;
        logic                hit;
        logic [STATUS_W-1:0] status;
        logic [TOTAL_W-1:0]  total;
    } t_steer_result;

    // Predict the flow table and worker rotation, and hold the results still due
    class steering_scoreboard;
        bit [KEY_W-1:0]    slot_key    [FLOW_SLOTS];
        bit [WORKER_W-1:0] slot_worker [FLOW_SLOTS];
        bit                slot_used   [FLOW_SLOTS];
        bit [WORKER_W-1:0] rota        [LIST_SLOTS];
        int unsigned       rota_len;
        bit [63:0]         rotation;
        t_steer_result     awaited [$];
        int unsigned       errors;

        function int find_slot(bit [KEY_W-1:0] key);
            for (int i = 0; i < FLOW_SLOTS; i++)
                if (slot_used[i] && slot_key[i] == key) return i;
            return -1;
        endfunction

        function int free_slot();
            for (int i = 0; i < FLOW_SLOTS; i++)
                if (!slot_used[i]) return i;
            return -1;
        endfunction

        task report(string msg);
            if (errors < MAX_PRINTED) $display("tb: mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        // Work out the result of one accepted request and queue it
        function void note_request(bit [ACTION_W-1:0] action, bit [KEY_W-1:0] key,
                                   bit [WORKER_W-1:0] worker_in);
            t_steer_result   want;
            int              slot;
            int unsigned     keep;
            bit [WORKER_W-1:0] w;
            bit [63:0]       idx;
            w = worker_in & ID_MASK;
            want = '0;
            want.status = STAT_OK;
            case (action)
                ACT_ADD: begin
                    slot = find_slot(key);
                    if (slot < 0) slot = free_slot();
                    if (slot < 0) begin
                        want.status = STAT_FULL;
                    end else begin
                        slot_key[slot]    = key;
                        slot_worker[slot] = w;
                        slot_used[slot]   = 1'b1;
                    end
                end
                ACT_REMOVE: begin
                    slot = find_slot(key);
                    if (slot < 0) want.status = STAT_NOTFOUND;
                    else slot_used[slot] = 1'b0;
                end
                ACT_REG: begin
                    if (rota_len >= LIST_SLOTS) want.status = STAT_FULL;
                    else rota[rota_len++] = w;
                end
                ACT_UNREG: begin
                    // drop every copy, keep the order of the rest
                    keep = 0;
                    for (int r = 0; r < rota_len; r++)
                        if (rota[r] != w) rota[keep++] = rota[r];
                    rota_len = keep;
                end
                ACT_LOOKUP: begin
                    slot = find_slot(key);
                    if (slot < 0) begin
                        want.status = STAT_NOTFOUND;
                    end else begin
                        want.worker_out = slot_worker[slot];
                        want.hit        = 1'b1;
                    end
                end
                ACT_ALLOC: begin
                    if (rota_len == 0) begin
                        want.status = STAT_NOWORK;
                    end else begin
                        idx = rotation % 64'(rota_len);
                        want.worker_out = rota[idx];
                        want.hit        = 1'b1;
                        rotation        = rotation + 64'd1;
                    end
                end
                default: ;
            endcase
            want.total = TOTAL_W'(rota_len);
            awaited = {awaited, want};
        endfunction

        // Compare one result strobe with the oldest prediction
        task check_result(t_steer_result got);
            t_steer_result want;
            if (awaited.size() == 0) begin
                report($sformatf("unexpected result worker %0d hit %0d status %0d total %0d",
                                 got.worker_out, got.hit, got.status, got.total));
                return;
            end
            want = awaited.pop_front();
            if (got.worker_out !== want.worker_out)
                report($sformatf("worker_out %0d, want %0d", got.worker_out, want.worker_out));
            if (got.hit !== want.hit)
                report($sformatf("hit %0d, want %0d", got.hit, want.hit));
            if (got.status !== want.status)
                report($sformatf("status %0d, want %0d", got.status, want.status));
            if (got.total !== want.total)
                report($sformatf("worker_total %0d, want %0d", got.total, want.total));
        endtask
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [ACTION_W-1:0] i_action = '0;
    logic [KEY_W-1:0]    i_cid_key = '0;
    logic [WORKER_W-1:0] i_worker = '0;
    logic                o_valid;
    logic [WORKER_W-1:0] o_worker_out;
    logic                o_hit;
    logic [STATUS_W-1:0] o_status;
    logic [TOTAL_W-1:0]  o_worker_total;

    steering_scoreboard sb;
    bit [KEY_W-1:0]    key_pool    [KEY_POOL_SIZE];
    bit [WORKER_W-1:0] worker_pool [WORKER_POOL_SIZE];

    connection_id_flow_steering dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_action       (i_action),
        .i_cid_key      (i_cid_key),
        .i_worker       (i_worker),
        .o_valid        (o_valid),
        .o_worker_out   (o_worker_out),
        .o_hit          (o_hit),
        .o_status       (o_status),
        .o_worker_total (o_worker_total)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // Check every result strobe
    always @(posedge i_clk) begin
        t_steer_result got;
        if (i_rst_n === 1'b1 && o_valid === 1'b1) begin
            got.worker_out = o_worker_out;
            got.hit        = o_hit;
            got.status     = o_status;
            got.total      = o_worker_total;
            sb.check_result(got);
        end
    end

    // Present one request from a falling edge and hold it until accepted
    task send_request(logic [ACTION_W-1:0] action, logic [KEY_W-1:0] key,
                      logic [WORKER_W-1:0] worker);
        i_action  <= action;
        i_cid_key <= key;
        i_worker  <= worker;
        start     <= 1'b1;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        sb.note_request(action, key, worker);
        @(negedge i_clk);
    endtask

    // Drop start for a while, with junk on the fields
    task sender_pause(int pct);
        int cycles;
        if ($urandom_range(0, 99) < pct) begin
            cycles = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 80) : $urandom_range(1, 6);
            start     <= 1'b0;
            i_action  <= ACTION_W'($urandom);
            i_cid_key <= {$urandom, $urandom};
            i_worker  <= WORKER_W'($urandom);
            repeat (cycles) @(negedge i_clk);
        end
    endtask

    function logic [ACTION_W-1:0] pick_action(int phase);
        int roll;
        int acc;
        logic [ACTION_W-1:0] codes [7];
        codes = '{ACT_ADD, ACT_REMOVE, ACT_REG, ACT_UNREG, ACT_LOOKUP, ACT_ALLOC, ACT_SPARE_LO};
        roll = $urandom_range(0, 99);
        acc  = 0;
        for (int a = 0; a < 7; a++) begin
            acc += MIX[phase][a];
            if (roll < acc) begin
                if (a == 6 && $urandom_range(0, 1) == 1) return ACT_SPARE_HI;
                return codes[a];
            end
        end
        return ACT_LOOKUP;
    endfunction

    function logic [KEY_W-1:0] pick_key();
        if ($urandom_range(0, 9) == 0) return {$urandom, $urandom};
        return key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
    endfunction

    function logic [WORKER_W-1:0] pick_worker();
        if ($urandom_range(0, 4) == 0) return WORKER_W'($urandom);
        return worker_pool[$urandom_range(0, WORKER_POOL_SIZE - 1)];
    endfunction

    // Extremes of the fields and each special case in turn
    task run_directed();
        send_request(ACT_ALLOC,  '0, '0);
        send_request(ACT_LOOKUP, '0, '0);
        send_request(ACT_REMOVE, '1, '0);
        send_request(ACT_ADD,    '0, 8'h00);
        send_request(ACT_ADD,    '1, 8'hFF);
        send_request(ACT_ADD,    '0, 8'hA5);
        send_request(ACT_LOOKUP, '0, '0);
        send_request(ACT_LOOKUP, '1, '0);
        send_request(ACT_REMOVE, '0, '0);
        send_request(ACT_LOOKUP, '0, '0);
        send_request(ACT_REG,    '0, 8'hFF);
        send_request(ACT_REG,    '0, 8'h00);
        send_request(ACT_REG,    '0, 8'hFF);
        send_request(ACT_REG,    '0, 8'h5A);
        repeat (5) send_request(ACT_ALLOC, '0, '0);
        send_request(ACT_UNREG,  '0, 8'hFF);
        send_request(ACT_UNREG,  '0, 8'h77);
        send_request(ACT_ALLOC,  '0, '0);
        send_request(ACT_SPARE_LO, '1, 8'hFF);
        send_request(ACT_SPARE_HI, '1, 8'hFF);
        send_request(ACT_UNREG,  '0, 8'h00);
        send_request(ACT_UNREG,  '0, 8'h5A);
        send_request(ACT_ALLOC,  '0, '0);
    endtask

    initial begin
        int guard;
        sb = new;
        // Seed the key and worker pools, small enough for hits and a full table
        key_pool[0] = '0;
        key_pool[1] = '1;
        key_pool[2] = 64'h8000_0000_0000_0000;
        key_pool[3] = 64'h1;
        for (int i = 4; i < KEY_POOL_SIZE; i++) key_pool[i] = {$urandom, $urandom};
        worker_pool[0] = 8'h00;
        worker_pool[1] = 8'hFF;
        for (int i = 2; i < WORKER_POOL_SIZE; i++) worker_pool[i] = WORKER_W'($urandom);

        // Hold reset, then release on a falling edge
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        run_directed();

        // Random requests, phase by phase
        for (int phase = 0; phase < PHASES; phase++) begin
            for (int n = 0; n < REQS_PER_PHASE; n++) begin
                send_request(pick_action(phase), pick_key(), pick_worker());
                sender_pause(IDLE_PCT[phase]);
            end
        end
        start <= 1'b0;

        // Wait for outstanding results, then watch for strays
        guard = 0;
        while (sb.awaited.size() != 0 && guard < SETTLE_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.awaited.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.awaited.size()));

        if (sb.errors == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #TIMEOUT_NS;
        $display("tb: done, errors");
        $finish;
    end

endmodule
